// ----- design/vrp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrp_pkg
// shared types and constants of the video register port
// ----------------------------------------------------------------------------
package vrp_pkg;

   localparam int NAMETABLE_BYTES  = 4096;
   localparam int SPRITE_RAM_BYTES = 256;
   localparam int NT_AW = $clog2(NAMETABLE_BYTES);
   localparam int SP_AW = $clog2(SPRITE_RAM_BYTES);

   localparam logic [2:0] ACT_READ   = 3'd0;
   localparam logic [2:0] ACT_WRITE  = 3'd1;
   localparam logic [2:0] ACT_VBLANK = 3'd2;
   localparam logic [2:0] ACT_PRERND = 3'd3;
   localparam logic [2:0] ACT_SPR0   = 3'd4;

   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_OAMADR = 3'd3;
   localparam logic [2:0] REG_OAMDAT = 3'd4;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam logic [1:0] MIR_VERT = 2'd0;
   localparam logic [1:0] MIR_HORZ = 2'd1;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] register_index;
      logic [7:0] write_data;
      logic [7:0] pattern_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        nmi_request;
      logic        pattern_write;
      logic [12:0] pattern_address;
      logic [7:0]  pattern_write_data;
      logic [15:0] current_vram_address;
      logic [15:0] temp_vram_address;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  render_control;
      logic [7:0]  render_mask;
   } rsp_type;

endpackage

// ----- design/video_register_port_vram_access.sv -----
// ----------------------------------------------------------------------------
// video_register_port_vram_access
// cpu register port with scroll registers, oam, nametable and palette ram
// ----------------------------------------------------------------------------
// channel | ports       | direction | content
// req     | req_*       | in        | register access or timing event item
// rsp     | rsp_*       | out       | read data, nmi level, pattern access, state
// csr     | csr_*       | in        | mirroring mode
//
// per item, the accept edge reads oam and nametable ram, and the exec
// state then modifies and writes back and loads the output register.
// after reset a clearing pass zeroes every byte of the nametable ram;
// no item is taken meanwhile.
// a held result stalls the write-back of the following item.
// ----------------------------------------------------------------------------
module video_register_port_vram_access
   import vrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [NT_AW-1:0] clr_ff;
   req_type     item_ff;
   logic [1:0]  mirror_ff;
   logic [7:0]  ctrl_ff, ctrl_in, mask_ff, mask_in, status_ff, status_in;
   logic [7:0]  ptr_ff, ptr_in, rbuf_ff, rbuf_in;
   logic [15:0] cur_ff, cur_in, tmp_ff, tmp_in;
   logic [2:0]  fx_ff, fx_in;
   logic        tog_ff, tog_in, nmi_ff, nmi_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [7:0]  nt_mem [NAMETABLE_BYTES];
   logic [7:0]  sp_mem [SPRITE_RAM_BYTES];
   logic [SPRITE_RAM_BYTES-1:0] sp_valid_ff;
   logic [7:0]  pal_ff [32];
   logic [7:0]  nt_rd_ff, sp_rd_ff;
   logic        sp_vld_rd_ff;

   logic [13:0] addr;
   logic [NT_AW-1:0] nt_idx;
   logic [4:0]  pal_idx;
   logic        go, nt_we, sp_we, pal_we;
   logic [7:0]  sp_rd;

   always_comb begin
      logic [11:0] a;
      logic [11:0] r;
      a = cur_ff[11:0];
      case (mirror_ff)
         MIR_VERT: begin
            r = {1'b0, a[10:0]};
         end
         MIR_HORZ: begin
            r = {1'b0, a[11], a[9:0]};
         end
         default: begin
            r = a;
         end
      endcase
      nt_idx = r[NT_AW-1:0];
   end

   assign addr    = cur_ff[13:0];
   assign pal_idx = (cur_ff[4] && cur_ff[1:0] == 2'b00) ? {1'b0, cur_ff[3:0]} : cur_ff[4:0];
   assign sp_rd   = sp_vld_rd_ff ? sp_rd_ff : 8'd0;
   assign go      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [7:0] v;
      v = item_ff.write_data;
      ctrl_in = ctrl_ff; mask_in = mask_ff; status_in = status_ff; ptr_in = ptr_ff;
      rbuf_in = rbuf_ff; cur_in = cur_ff; tmp_in = tmp_ff; fx_in = fx_ff;
      tog_in = tog_ff; nmi_in = nmi_ff;
      nt_we = 1'b0; sp_we = 1'b0; pal_we = 1'b0;
      rsp_in = '0;
      case (item_ff.action)
         ACT_READ: begin
            case (item_ff.register_index)
               REG_STATUS: begin
                  rsp_in.read_data = {status_ff[7:5], rbuf_ff[4:0]};
                  status_in = {1'b0, status_ff[6:0]};
                  nmi_in = 1'b0;
                  tog_in = 1'b0;
               end
               REG_OAMDAT: begin
                  rsp_in.read_data = sp_rd;
               end
               REG_DATA: begin
                  rsp_in.read_data = rbuf_ff;
                  if (addr < 14'h2000) begin
                     rbuf_in = item_ff.pattern_data;
                     rsp_in.pattern_address = addr[12:0];
                  end else if (addr < 14'h3F00) begin
                     rbuf_in = nt_rd_ff;
                  end else begin
                     rsp_in.read_data = pal_ff[pal_idx];
                     rbuf_in = nt_rd_ff;
                  end
                  cur_in = cur_ff + (ctrl_ff[2] ? 16'd32 : 16'd1);
               end
               default: begin
               end
            endcase
         end
         ACT_WRITE: begin
            case (item_ff.register_index)
               REG_CTRL: begin
                  ctrl_in = v;
                  tmp_in = {tmp_ff[15:12], v[1:0], tmp_ff[9:0]};
                  if (v[7] && status_ff[7]) nmi_in = 1'b1;
               end
               REG_MASK: begin
                  mask_in = v;
               end
               REG_OAMADR: begin
                  ptr_in = v;
               end
               REG_OAMDAT: begin
                  sp_we = 1'b1;
                  ptr_in = ptr_ff + 8'd1;
               end
               REG_SCROLL: begin
                  if (!tog_ff) begin
                     fx_in = v[2:0];
                     tmp_in = {tmp_ff[15:5], v[7:3]};
                  end else begin
                     tmp_in = {tmp_ff[15], v[2:0], tmp_ff[11:10], v[7:3], tmp_ff[4:0]};
                  end
                  tog_in = !tog_ff;
               end
               REG_ADDR: begin
                  if (!tog_ff) begin
                     tmp_in = {2'b00, v[5:0], tmp_ff[7:0]};
                  end else begin
                     tmp_in = {tmp_ff[15:8], v};
                     cur_in = {tmp_ff[15:8], v};
                  end
                  tog_in = !tog_ff;
               end
               REG_DATA: begin
                  if (addr < 14'h2000) begin
                     rsp_in.pattern_write = 1'b1;
                     rsp_in.pattern_address = addr[12:0];
                     rsp_in.pattern_write_data = v;
                  end else if (addr < 14'h3F00) begin
                     nt_we = 1'b1;
                  end else begin
                     pal_we = 1'b1;
                  end
                  cur_in = cur_ff + (ctrl_ff[2] ? 16'd32 : 16'd1);
               end
               default: begin
               end
            endcase
         end
         ACT_VBLANK: begin
            status_in = status_ff | 8'h80;
            if (ctrl_ff[7]) nmi_in = 1'b1;
         end
         ACT_PRERND: begin
            status_in = status_ff & 8'h1F;
            nmi_in = 1'b0;
         end
         ACT_SPR0: begin
            status_in = status_ff | 8'h40;
         end
         default: begin
         end
      endcase
      rsp_in.nmi_request = nmi_in;
      rsp_in.current_vram_address = cur_in;
      rsp_in.temp_vram_address = tmp_in;
      rsp_in.fine_scroll_x = fx_in;
      rsp_in.render_control = ctrl_in;
      rsp_in.render_mask = mask_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NT_AW'(NAMETABLE_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memories, item register and result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         nt_mem[clr_ff] <= 8'd0;
      end else if (go && nt_we) begin
         nt_mem[nt_idx] <= item_ff.write_data;
      end
      nt_rd_ff <= nt_mem[nt_idx];
      if (go && sp_we) begin
         sp_mem[ptr_ff[SP_AW-1:0]] <= item_ff.write_data;
      end
      sp_rd_ff <= sp_mem[ptr_ff[SP_AW-1:0]];
      sp_vld_rd_ff <= sp_valid_ff[ptr_ff[SP_AW-1:0]];
      if (req_valid && req_ready) item_ff <= req_data;
      if (go) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         mirror_ff <= MIR_VERT;
         ctrl_ff <= '0; mask_ff <= '0; status_ff <= '0; ptr_ff <= '0; rbuf_ff <= '0;
         cur_ff <= '0; tmp_ff <= '0; fx_ff <= '0; tog_ff <= 1'b0; nmi_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sp_valid_ff <= '0;
         for (int i = 0; i < 32; i++) pal_ff[i] <= 8'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + NT_AW'(1);
         if (csr_valid) mirror_ff <= csr_data;
         if (go) begin
            ctrl_ff <= ctrl_in; mask_ff <= mask_in; status_ff <= status_in;
            ptr_ff <= ptr_in; rbuf_ff <= rbuf_in; cur_ff <= cur_in; tmp_ff <= tmp_in;
            fx_ff <= fx_in; tog_ff <= tog_in; nmi_ff <= nmi_in;
            if (sp_we) sp_valid_ff[ptr_ff[SP_AW-1:0]] <= 1'b1;
            if (pal_we) pal_ff[pal_idx] <= item_ff.write_data;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- design/vrp_checker.sv -----
// ----------------------------------------------------------------------------
// vrp_checker
// port-level checks of the video register port
// ----------------------------------------------------------------------------
module vrp_checker
   import vrp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not empty after reset");

   a_write_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pattern_write |-> rsp_data.read_data == 8'd0)
      else $error("pattern write item carries read data");

endmodule

bind video_register_port_vram_access vrp_checker u_vrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
